/* hw/rtl/nmea_sentence_framer_classifier_defines.svh */
// Assertion macros of the NMEA sentence framer and classifier, used by its top level.
// Needs nothing else; files that assert include it by its bare name.
`ifndef NMEA_SENTENCE_FRAMER_CLASSIFIER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nsfc_pkg.sv */
// Types, codes and lookup tables of the NMEA sentence framer and classifier.
// No dependencies; every other RTL file imports it.
`default_nettype none

package nsfc_pkg;

  localparam int HEADER_BYTES   = 5;
  localparam int HDR_IDX_W      = $clog2(HEADER_BYTES);
  localparam int TALKER_COUNT   = 96;
  localparam int SENTENCE_COUNT = 65;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_P      = 8'h50;

  localparam logic [7:0] MAX_MSG_RESET = 8'd82;

  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FRAMING  = 2'd2;

  localparam logic [6:0] TALKER_UNKNOWN     = 7'd0;
  localparam logic [6:0] TALKER_PROPRIETARY = 7'd1;
  localparam logic [6:0] SENTENCE_UNKNOWN   = 7'd0;

  localparam logic [8*2*TALKER_COUNT-1:0] TALKER_TABLE = {
    "ABADAGAIANAPARASATAX", "BIBN", "CACDCRCSCTCVCX", "DEDFDPDU", "ECEIEPER",
    "FDFEFRFS", "GAGBGIGLGNGPGQ", "HCHDHEHFHNHS", "IIIN", "JAJBJCJDJEJFJGJH",
    "LCMXNLNV", "RARBRCRI", "SASCSDSGSNSS", "TCTI", "U0U1U2U3U4U5U6U7U8U9UP",
    "VAVDVMVRVSVTVW", "WDWIWL", "YXZAZCZQZV"
  };

  localparam logic [8*3*SENTENCE_COUNT-1:0] SENTENCE_TABLE = {
    "AAMALMAPAAPBASD", "BECBODBWCBWRBWW", "DBTDCNDPTDTM", "FSI",
    "GGAGLCGLLGRSGSAGSTGSVGXA", "HDGHDTHSC", "LCD", "MSKMSSMTAMTWMWDMWV",
    "OLNOSD", "R00RMARMBRMCROTRPMRSARSDRTE", "SFISTN", "TRFTTMTXT",
    "VBWVDRVHWVLWVPWVTG", "WCVWNCWPL", "XDRXTCXTEXTR", "ZDAZFOZTG"
  };

  typedef logic [HEADER_BYTES-1:0][7:0] header_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [8:0] length;
    header_t    header;
  } event_t;

  function automatic logic [6:0] talker_lookup(input logic [7:0] c0, input logic [7:0] c1);
    logic [6:0] code;
    code = TALKER_UNKNOWN;
    for (int i = TALKER_COUNT - 1; i >= 0; i--) begin
      if (TALKER_TABLE[8*(2*TALKER_COUNT-1-2*i) +: 8] == c0 &&
          TALKER_TABLE[8*(2*TALKER_COUNT-2-2*i) +: 8] == c1) begin
        code = 7'(i + 2);
      end
    end
    if (c0 == CH_P) begin
      code = TALKER_PROPRIETARY;
    end
    return code;
  endfunction

  function automatic logic [6:0] sentence_lookup(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [7:0] c2);
    logic [6:0] code;
    code = SENTENCE_UNKNOWN;
    for (int i = SENTENCE_COUNT - 1; i >= 0; i--) begin
      if (SENTENCE_TABLE[8*(3*SENTENCE_COUNT-1-3*i) +: 8] == c0 &&
          SENTENCE_TABLE[8*(3*SENTENCE_COUNT-2-3*i) +: 8] == c1 &&
          SENTENCE_TABLE[8*(3*SENTENCE_COUNT-3-3*i) +: 8] == c2) begin
        code = 7'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/nsfc_if.sv */
// Channel interfaces of the NMEA sentence framer and classifier.
// Depends on nsfc_pkg.
`default_nettype none

interface nsfc_byte_if import nsfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfc_result_if import nsfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] talker_code;
  logic [6:0] sentence_code;
  logic [8:0] frame_length;

  modport source (output valid, output status, output talker_code, output sentence_code,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input talker_code, input sentence_code,
                  input frame_length, output ready);
endinterface

interface nsfc_cfg_if import nsfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nsfc_framer.sv */
// Framing state machine: hunts for the start delimiter, keeps the header bytes
// and registers one event per finished frame or error. Depends on nsfc_pkg, nsfc_if.
`default_nettype none

module nsfc_framer import nsfc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  nsfc_byte_if.sink   rx,
  nsfc_cfg_if.sink    cfg,
  output event_t      ev,
  input  wire logic   ev_ready
);

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_WAIT_CR = 2'd1;
  localparam logic [1:0] PH_WAIT_LF = 2'd2;

  logic [7:0]        max_message_bytes;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [7:0]        byte_count;
  logic [7:0]        byte_count_next;
  header_t           header;
  logic              hdr_write;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic              hit;
  logic [1:0]        hit_status;
  logic              rx_fire;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !ev.valid || ev_ready;
  assign rx_fire   = rx.valid && rx.ready;
  assign hdr_idx   = HDR_IDX_W'(byte_count - 8'd1);

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    hdr_write       = 1'b0;
    hit             = 1'b0;
    hit_status      = ST_COMPLETE;
    unique case (phase)
      PH_WAIT_CR: begin
        if (rx.rx_byte == CH_CR) begin
          phase_next = PH_WAIT_LF;
        end else if (byte_count >= max_message_bytes) begin
          hit        = 1'b1;
          hit_status = ST_FULL;
        end else begin
          hdr_write       = (byte_count >= 8'd1) && (byte_count <= 8'(HEADER_BYTES));
          byte_count_next = byte_count + 8'd1;
        end
      end
      PH_WAIT_LF: begin
        phase_next      = PH_SEARCH;
        byte_count_next = 8'd0;
        hit             = 1'b1;
        hit_status      = (rx.rx_byte == CH_LF) ? ST_COMPLETE : ST_FRAMING;
      end
      default: begin
        phase_next      = PH_SEARCH;
        byte_count_next = 8'd0;
        if (rx.rx_byte == CH_DOLLAR) begin
          phase_next      = PH_WAIT_CR;
          byte_count_next = 8'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_MSG_RESET;
      phase             <= PH_SEARCH;
      byte_count        <= 8'd0;
      ev.valid          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_message_bytes <= cfg.data;
      end
      if (rx_fire) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        ev.valid   <= hit;
      end else if (ev_ready) begin
        ev.valid <= 1'b0;
      end
    end
    if (rx_fire && hit) begin
      ev.status <= hit_status;
      ev.length <= {1'b0, byte_count} + 9'd1;
      ev.header <= header;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && hdr_write) begin
      header[hdr_idx] <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nsfc_classifier.sv */
// Talker and sentence type lookup of a finished frame, into the result register.
// Depends on nsfc_pkg and nsfc_if.
`default_nettype none

module nsfc_classifier import nsfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire event_t   ev,
  output logic          ev_ready,
  nsfc_result_if.source result
);

  logic [6:0] talker;
  logic [6:0] sentence;
  logic       prop;

  assign ev_ready = !result.valid || result.ready;
  assign prop     = (ev.header[0] == CH_P);
  assign talker   = talker_lookup(ev.header[0], ev.header[1]);
  assign sentence = prop ? sentence_lookup(ev.header[1], ev.header[2], ev.header[3])
                         : sentence_lookup(ev.header[2], ev.header[3], ev.header[4]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ev_ready) begin
      result.valid <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev.valid) begin
      result.status <= ev.status;
      if (ev.status == ST_COMPLETE) begin
        result.talker_code   <= talker;
        result.sentence_code <= sentence;
        result.frame_length  <= ev.length;
      end else begin
        result.talker_code   <= TALKER_UNKNOWN;
        result.sentence_code <= SENTENCE_UNKNOWN;
        result.frame_length  <= 9'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nmea_sentence_framer_classifier.sv */
// Top level of the NMEA sentence framer and classifier.
// Depends on nsfc_pkg, nsfc_if, nsfc_framer, nsfc_classifier and the defines header.
//
//   channel  direction  beat
//   rx       in         one received byte
//   cfg      in         max_message_bytes write, always ready
//   result   out        status, talker code, sentence code, frame length
//
// One byte is taken every cycle unless the event register is stalled. The path of a
// result is the framer event register and then the parallel table compares in front
// of the result register.
// Reset is synchronous and clears the phase, the count, the limit and both valids.
// A stalled result holds back rx only when the event register behind it is full.
`default_nettype none
`include "nmea_sentence_framer_classifier_defines.svh"

module nmea_sentence_framer_classifier import nsfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  nsfc_byte_if.sink     rx,
  nsfc_cfg_if.sink      cfg,
  nsfc_result_if.source result
);

  event_t ev;
  logic   ev_ready;

  nsfc_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg),
    .ev       (ev),
    .ev_ready (ev_ready)
  );

  nsfc_classifier u_classifier (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .ev_ready (ev_ready),
    .result   (result)
  );

  `NSFC_ASSERT_NOW(a_err_fields_zero, clk, rst,
    result.valid && (result.status != ST_COMPLETE),
    (result.talker_code == 7'd0) && (result.sentence_code == 7'd0) &&
    (result.frame_length == 9'd0), "error result carries nonzero fields")
  `NSFC_ASSERT_NOW(a_complete_length, clk, rst,
    result.valid && (result.status == ST_COMPLETE), result.frame_length >= 9'd2,
    "complete frame shorter than the start delimiter")
  `NSFC_ASSERT_NOW(a_no_accept_when_blocked, clk, rst,
    ev.valid && !ev_ready, !rx.ready, "byte taken while event register is blocked")
  `NSFC_ASSERT_NEXT(a_event_moves, clk, rst,
    ev.valid && ev_ready, result.valid, "event lost on its way to the result register")

endmodule

`default_nettype wire

/* tb/nmea_sentence_framer_classifier_tb.sv */
// Self-checking testbench for nmea_sentence_framer_classifier: byte stream in, frame reports out.
// Depends on nsfc_pkg, the nsfc_if channel interfaces and the RTL of the block.
// A cycle-free frame tracker predicts each report; a monitor compares every result beat.
`default_nettype none

module nmea_sentence_framer_classifier_tb;
  import nsfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    HUNT     = 2'd0,
    COLLECT  = 2'd1,
    AWAIT_LF = 2'd2
  } frame_phase_e;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] talker;
    logic [6:0] sentence;
    logic [8:0] length;
  } frame_report_t;

  logic clk;
  logic rst;

  nsfc_byte_if   rx_ch ();
  nsfc_cfg_if    cfg_ch ();
  nsfc_result_if res_ch ();

  nmea_sentence_framer_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  string talker_ids = {
    "ABADAGAIANAPARASATAX", "BIBN", "CACDCRCSCTCVCX", "DEDFDPDU", "ECEIEPER",
    "FDFEFRFS", "GAGBGIGLGNGPGQ", "HCHDHEHFHNHS", "IIIN", "JAJBJCJDJEJFJGJH",
    "LCMXNLNV", "RARBRCRI", "SASCSDSGSNSS", "TCTI", "U0U1U2U3U4U5U6U7U8U9UP",
    "VAVDVMVRVSVTVW", "WDWIWL", "YXZAZCZQZV"
  };

  string sentence_ids = {
    "AAMALMAPAAPBASD", "BECBODBWCBWRBWW", "DBTDCNDPTDTM", "FSI",
    "GGAGLCGLLGRSGSAGSTGSVGXA", "HDGHDTHSC", "LCD", "MSKMSSMTAMTWMWDMWV",
    "OLNOSD", "R00RMARMBRMCROTRPMRSARSDRTE", "SFISTN", "TRFTTMTXT",
    "VBWVDRVHWVLWVPWVTG", "WCVWNCWPL", "XDRXTCXTEXTR", "ZDAZFOZTG"
  };

  logic [7:0]    max_bytes;
  frame_phase_e  phase;
  logic [7:0]    stored_count;
  logic [7:0]    header [HEADER_BYTES];
  logic [4:0]    header_seen;
  frame_report_t pending_reports [$];

  int  mismatch_count = 0;
  int  accepted_bytes = 0;
  int  hold_cycles    = 0;
  bit  sender_steady   = 1'b0;
  bit  receiver_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [6:0] talker_code_of();
    if (header[0] == CH_P) begin
      return TALKER_PROPRIETARY;
    end
    for (int i = 0; i < TALKER_COUNT; i++) begin
      if (talker_ids[2*i] == header[0] && talker_ids[2*i+1] == header[1]) begin
        return 7'(i + 2);
      end
    end
    return TALKER_UNKNOWN;
  endfunction

  function automatic logic [6:0] sentence_code_of(input logic [6:0] talker);
    int base;
    base = (talker == TALKER_PROPRIETARY) ? 1 : 2;
    for (int i = 0; i < SENTENCE_COUNT; i++) begin
      if (sentence_ids[3*i] == header[base] && sentence_ids[3*i+1] == header[base+1] &&
          sentence_ids[3*i+2] == header[base+2]) begin
        return 7'(i + 1);
      end
    end
    return SENTENCE_UNKNOWN;
  endfunction

  // A frame may only be classified once every header entry it reads has been written.
  function automatic bit header_readable();
    if (!header_seen[0]) begin
      return 1'b0;
    end
    if (header[0] == CH_P) begin
      return &header_seen[3:0];
    end
    return &header_seen;
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    frame_report_t rep;
    logic [6:0] talker;
    rep = '0;
    case (phase)
      COLLECT: begin
        if (b == CH_CR) begin
          phase = AWAIT_LF;
        end else if (stored_count >= max_bytes) begin
          rep.status = ST_FULL;
          pending_reports.push_back(rep);
        end else begin
          if (stored_count >= 1 && stored_count <= HEADER_BYTES) begin
            header[stored_count-1] = b;
            header_seen[stored_count-1] = 1'b1;
          end
          stored_count = stored_count + 8'd1;
        end
      end
      AWAIT_LF: begin
        phase = HUNT;
        if (b == CH_LF) begin
          talker = talker_code_of();
          rep.status   = ST_COMPLETE;
          rep.talker   = talker;
          rep.sentence = sentence_code_of(talker);
          rep.length   = 9'(stored_count) + 9'd1;
        end else begin
          rep.status = ST_FRAMING;
        end
        stored_count = 8'd0;
        pending_reports.push_back(rep);
      end
      default: begin
        phase = HUNT;
        stored_count = 8'd0;
        if (b == CH_DOLLAR) begin
          phase = COLLECT;
          stored_count = 8'd1;
        end
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic [7:0] v;
    int gap;
    v = b;
    if (phase == AWAIT_LF && v == CH_LF && !header_readable()) begin
      v = "X";
    end
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= v;
    do @(posedge clk); while (!rx_ch.ready);
    if (phase != HUNT || v == CH_DOLLAR) begin
      accepted_bytes++;
    end
    track_byte(v);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    max_bytes = value;
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] v;
    if ($urandom_range(0, 99) < 80) begin
      return 8'($urandom_range(8'h20, 8'h7E));
    end
    do v = 8'($urandom_range(0, 255)); while (v == CH_CR);
    return v;
  endfunction

  task automatic send_random_sentence(input int long_body);
    logic [7:0] head [HEADER_BYTES];
    logic [7:0] v;
    int r;
    int idx;
    int head_len;
    int body_len;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      idx = $urandom_range(0, TALKER_COUNT - 1);
      head[0] = talker_ids[2*idx];
      head[1] = talker_ids[2*idx+1];
    end else if (r < 80) begin
      head[0] = CH_P;
      head[1] = body_byte();
    end else if (r < 90) begin
      head[0] = 8'("A" + $urandom_range(0, 25));
      head[1] = 8'("A" + $urandom_range(0, 25));
    end else begin
      head[0] = body_byte();
      head[1] = body_byte();
    end
    if ($urandom_range(0, 99) < 80) begin
      idx = $urandom_range(0, SENTENCE_COUNT - 1);
      for (int k = 0; k < 3; k++) begin
        head[2+k] = sentence_ids[3*idx+k];
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        head[2+k] = 8'("A" + $urandom_range(0, 25));
      end
    end
    if (head[0] == CH_P) begin
      for (int k = 1; k < HEADER_BYTES; k++) begin
        head[k] = head[k+1 < HEADER_BYTES ? k+1 : k];
      end
    end
    head_len = ($urandom_range(0, 99) < 6) ? $urandom_range(0, 4) : HEADER_BYTES;
    body_len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 15)
                                             : $urandom_range(0, long_body);
    send_byte(CH_DOLLAR);
    for (int k = 0; k < head_len; k++) begin
      send_byte(head[k]);
    end
    for (int k = 0; k < body_len; k++) begin
      send_byte(body_byte());
    end
    r = $urandom_range(0, 99);
    send_byte(CH_CR);
    if (r < 85) begin
      send_byte(CH_LF);
    end else begin
      do v = 8'($urandom_range(0, 255)); while (v == CH_LF);
      send_byte(v);
    end
  endtask

  task automatic random_traffic(input int budget, input int long_body);
    int stop_at;
    stop_at = accepted_bytes + budget;
    while (accepted_bytes < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        sender_steady = !sender_steady;
      end
      if ($urandom_range(0, 19) == 0) begin
        receiver_steady = !receiver_steady;
      end
      if ($urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      send_random_sentence(long_body);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  task automatic test_classification();
    send_text("$GPGGA,1\r\n");
    send_text("$PRMC\r\n");
    send_text("$ABAAM\r\n");
    send_text("$ZVZTG\r\n");
    send_text("$QQXYZ\r\n");
    send_text("$\r\n");
    send_text("$GP$GA\r\n");
  endtask

  task automatic test_framing_and_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_text("$GPRMC\rX");
    send_text("$GPGLL\r$");
    send_text("$GPVTG\r\r");
    send_byte(8'hAA);
    send_byte(8'h55);
  endtask

  task automatic test_buffer_limit();
    write_limit(8'd10);
    send_text("$GPGSV,abcdef\r\n");
    write_limit(8'd3);
    send_text("$GPGGA\r\n");
    write_limit(8'd255);
    send_text("$GNRMC,");
    repeat (260) send_byte(body_byte());
    send_text("\r\n");
    write_limit(MAX_MSG_RESET);
  endtask

  task automatic test_backpressure();
    wait_idle();
    sender_steady = 1'b1;
    hold_cycles = 100;
    repeat (15) send_text("$GPGGA\r\n");
    sender_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_limits();
    random_traffic(450, 90);
    write_limit(8'd255);
    random_traffic(300, 270);
    write_limit(8'd10);
    random_traffic(250, 20);
    write_limit(8'($urandom_range(10, 255)));
    random_traffic(250, 120);
    write_limit(MAX_MSG_RESET);
    random_traffic(150, 90);
  endtask

  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (receiver_steady || $urandom_range(0, 99) < 70) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap(1'b0) + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.status, res_ch.talker_code, res_ch.sentence_code, res_ch.frame_length};
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: status %0d talker %0d sentence %0d length %0d",
                   got.status, got.talker, got.sentence, got.length);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.status, want.talker, want.sentence, want.length,
                     got.status, got.talker, got.sentence, got.length);
          end
        end
      end
    end
  end

  initial begin
    int waited;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= 8'h00;
    max_bytes     = MAX_MSG_RESET;
    phase         = HUNT;
    stored_count  = 8'd0;
    header_seen   = '0;
    for (int k = 0; k < HEADER_BYTES; k++) begin
      header[k] = 8'h00;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_classification();
    test_framing_and_noise();
    test_buffer_limit();
    test_backpressure();
    test_random_limits();

    rx_ch.valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/nsfc_pkg.sv
hw/rtl/nsfc_if.sv
hw/rtl/nsfc_framer.sv
hw/rtl/nsfc_classifier.sv
hw/rtl/nmea_sentence_framer_classifier.sv
tb/nmea_sentence_framer_classifier_tb.sv
